// File: hdl/audio_capture_conditioner_macros.svh
// Assertion macros shared by the block's checks.
`ifndef AUDIO_CAPTURE_CONDITIONER_MACROS_SVH
`define AUDIO_CAPTURE_CONDITIONER_MACROS_SVH

// The consequent must hold in the same cycle as the trigger.
`define ACC_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define ACC_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: hdl/acc_pkg.sv
`default_nettype none
package acc_pkg;

    localparam int MAX_FRAME_SAMPLES = 4096;
    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int LIMIT_DEPTH = 1024;

    localparam int POS_W = $clog2(MAX_FRAME_SAMPLES);
    localparam int ADDR_W = POS_W + 1;
    localparam int FRAME_W = 13;
    localparam int CH_W = $clog2(MAX_CHANNELS);
    localparam int CHCNT_W = 4;
    localparam int GAIN_W = 16;
    localparam int ENERGY_W = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LIM_SHIFT = 15 - $clog2(LIMIT_DEPTH);
    localparam int LIM_IDX_W = $clog2(LIMIT_DEPTH + 1);

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd16384;
    localparam logic [GAIN_W-1:0] GAIN_MIN = 16'd10650;
    localparam logic [GAIN_W-1:0] GAIN_MAX = 16'd36045;
    localparam logic [GAIN_W-1:0] K_FALL = 16'd19661;
    localparam logic [GAIN_W-1:0] K_RISE = 16'd5243;
    localparam logic [GAIN_W-1:0] VOLUME_MAX = 16'd32768;
    localparam logic [23:0] RMS_FLOOR = 24'd67109;
    localparam logic [47:0] AGC_NUM = 48'd15118284882;
    localparam logic [16:0] GATE_CLOSE = 17'd131;
    localparam logic [16:0] GATE_OPEN = 17'd360;
    localparam logic [16:0] GATE_HALF = 17'd114;
    localparam logic [16:0] GATE_RECIP = 17'd73263;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_SAMPLES = 3'd0,
        REG_CHANNEL_COUNT = 3'd1,
        REG_HPF_COEFFICIENT = 3'd2,
        REG_HPF_ENABLE = 3'd3,
        REG_GATE_ENABLE = 3'd4,
        REG_AGC_ENABLE = 3'd5,
        REG_VOLUME_GAIN = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic start;
        logic agc_enable;
    } fend_ctrl_t;

    typedef logic [15:0] limit_table_t [0:LIMIT_DEPTH];

    // Shift-subtract quotient, used only while the limiter table is built.
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            r = (r << 1) | ((num >> b) & 64'd1);
            if (r >= den) begin
                r -= den;
                q |= 64'd1 << b;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned exp_q28(longint unsigned x);
        longint unsigned sum;
        longint unsigned term;
        sum = 64'd1 << 28;
        term = 64'd1 << 28;
        for (int k = 1; k < 64; k++) begin
            term = udiv64((term * x) >> 28, longint'(k));
            if (term == 0) break;
            sum += term;
        end
        return sum;
    endfunction

    function automatic longint unsigned tanh_half_q30(longint unsigned x);
        longint unsigned e;
        e = exp_q28(x);
        return udiv64((e - (64'd1 << 28)) << 30, e + (64'd1 << 28));
    endfunction

    function automatic limit_table_t build_limit_table();
        limit_table_t t;
        longint unsigned tb;
        longint unsigned x;
        longint unsigned ta;
        tb = tanh_half_q30(64'd858993459);
        for (int i = 0; i <= LIMIT_DEPTH; i++) begin
            x = longint'(i) * 64'd858993459 / LIMIT_DEPTH;
            ta = tanh_half_q30(x);
            t[i] = 16'(udiv64(ta * 64'd65536 + tb, 64'd2 * tb));
        end
        return t;
    endfunction

    localparam limit_table_t LIMIT_TABLE = build_limit_table();

endpackage
`default_nettype wire

// File: hdl/acc_stream_if.sv
`default_nettype none
interface acc_in_if;
    import acc_pkg::*;
    logic valid;
    logic ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    modport source(output valid, output sample_in, input ready);
    modport sink(input valid, input sample_in, output ready);
endinterface

interface acc_out_if;
    import acc_pkg::*;
    logic valid;
    logic ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic frame_last;
    logic [GAIN_W-1:0] gain_applied;
    modport source(output valid, output sample_out, output frame_last, output gain_applied,
                   input ready);
    modport sink(input valid, input sample_out, input frame_last, input gain_applied,
                 output ready);
endinterface
`default_nettype wire

// File: hdl/audio_capture_conditioner.sv
`default_nettype none
// Audio capture conditioner: interleaved Q1.15 samples go through an optional per-channel
// high-pass filter into a double-buffered frame memory while their energy is summed;
// each accepted item returns one result, the conditioned sample at the same position of
// the previous frame (noise gate, AGC gain and volume, tanh soft limiter), and results are
// zero until the first frame is complete. An item passes through the frame memory read, the
// filter and gain multipliers and the limiter table lookup, and its result register waits
// for the sink when it stalls; the last item of a frame then waits for the frame-end unit,
// whose shared shift-subtract divider and square-root loop (48 + 24 + 48 steps, or none with
// AGC off) produce the new gain before the next item is taken.
module audio_capture_conditioner (
    input  logic                                clk,
    input  logic                                rst_n,
    acc_in_if.sink                              sample_stream,
    acc_out_if.source                           result_stream,
    input  logic                                cfg_we,
    input  logic [acc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [acc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import acc_pkg::*;
    `include "audio_capture_conditioner_macros.svh"

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_READ   = 10'b0000000010,
        ST_GATE   = 10'b0000000100,
        ST_DIV    = 10'b0000001000,
        ST_MUL1   = 10'b0000010000,
        ST_MUL2   = 10'b0000100000,
        ST_LIM    = 10'b0001000000,
        ST_INTERP = 10'b0010000000,
        ST_EMIT   = 10'b0100000000,
        ST_FEND   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [FRAME_W-1:0] frame_samples_reg;
    logic [CHCNT_W-1:0] channel_count_reg;
    logic [15:0] hpf_coef_reg;
    logic hpf_en_reg, gate_en_reg, agc_en_reg;
    logic [GAIN_W-1:0] volume_reg;

    logic signed [15:0] x_reg;
    logic [CH_W-1:0] ch_reg;
    logic [POS_W-1:0] pos_reg;
    logic last_reg;

    logic signed [15:0] hpf_in_reg [0:MAX_CHANNELS-1];
    logic signed [23:0] hpf_out_reg [0:MAX_CHANNELS-1];
    logic signed [41:0] hpf_prod_reg;

    logic [ENERGY_W-1:0] energy_reg;
    logic bank_reg, primed_reg;
    logic [POS_W-1:0] spos_reg;
    logic [CH_W-1:0] chpos_reg;
    logic [GAIN_W-1:0] smoothed_reg, frame_gain_reg;

    logic [16:0] gm_reg;
    logic gneg_reg, gzero_reg, gscale_reg;
    logic signed [15:0] s0_reg;
    logic signed [15:0] g_reg;
    logic signed [32:0] t_reg;
    logic signed [47:0] u_reg;
    logic signed [15:0] res_reg;

    logic out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic out_last_reg;
    logic [GAIN_W-1:0] out_gain_reg;

    logic [15:0] frame_mem [0:2*MAX_FRAME_SAMPLES-1];
    logic [15:0] rd_reg;

    logic [FRAME_W-1:0] n_eff;
    logic [CHCNT_W-1:0] nch_eff;
    logic [CH_W-1:0] ch_accept;
    logic accept;
    logic mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic signed [15:0] s_filt;
    logic signed [23:0] hpf_y;
    logic signed [41:0] hpf_round;
    logic signed [24:0] y_round;
    logic signed [24:0] hpf_sum;
    logic signed [16:0] s0x;
    logic [16:0] gate_mag;
    logic [33:0] gate_q;
    logic signed [16:0] gate_qs;
    logic [GAIN_W-1:0] vol_eff;
    logic signed [47:0] v_round;
    logic signed [16:0] v_clamp;
    logic [16:0] lim_mag;
    logic signed [15:0] lim_result;
    logic emit_load;
    fend_ctrl_t fend_ctrl;
    logic fend_done;
    logic [GAIN_W-1:0] fend_gain;

    always_comb
    begin
        if (frame_samples_reg == '0)
            n_eff = FRAME_W'(1);
        else if (frame_samples_reg > FRAME_W'(MAX_FRAME_SAMPLES))
            n_eff = FRAME_W'(MAX_FRAME_SAMPLES);
        else
            n_eff = frame_samples_reg;
        if (channel_count_reg == '0)
            nch_eff = CHCNT_W'(1);
        else if (channel_count_reg > CHCNT_W'(MAX_CHANNELS))
            nch_eff = CHCNT_W'(MAX_CHANNELS);
        else
            nch_eff = channel_count_reg;
        ch_accept = ({1'b0, chpos_reg} < nch_eff) ? chpos_reg : '0;
    end

    assign accept = sample_stream.valid && sample_stream.ready;
    assign sample_stream.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        hpf_sum = $signed({hpf_out_reg[ch_reg][23], hpf_out_reg[ch_reg]})
                  + ($signed({x_reg[15], x_reg} - {hpf_in_reg[ch_reg][15], hpf_in_reg[ch_reg]})
                     <<< 7);
        hpf_round = (hpf_prod_reg + 42'sd32768 - $signed({41'd0, hpf_prod_reg[41]})) >>> 16;
        if (hpf_round > 42'sd8388607)
            hpf_y = 24'sh7fffff;
        else if (hpf_round < -42'sd8388608)
            hpf_y = -24'sd8388608;
        else
            hpf_y = hpf_round[23:0];
        y_round = ($signed({hpf_y[23], hpf_y}) + 25'sd64 - $signed({24'd0, hpf_y[23]})) >>> 7;
        if (!hpf_en_reg)
            s_filt = x_reg;
        else if (y_round > 25'sd32767)
            s_filt = 16'sh7fff;
        else if (y_round < -25'sd32768)
            s_filt = -16'sd32768;
        else
            s_filt = y_round[15:0];

        s0x = $signed({rd_reg[15], rd_reg});
        gate_mag = s0x[16] ? 17'(-s0x) : 17'(s0x);
        gate_q = (34'(gm_reg) * 34'(GATE_RECIP)) >> 24;
        gate_qs = gneg_reg ? -$signed(gate_q[16:0]) : $signed(gate_q[16:0]);

        vol_eff = (volume_reg > VOLUME_MAX) ? VOLUME_MAX : volume_reg;
        v_round = (u_reg + 48'sd134217728 - $signed({47'd0, u_reg[47]})) >>> 28;
        if (v_round > 48'sd32768)
            v_clamp = 17'sd32768;
        else if (v_round < -48'sd32768)
            v_clamp = -17'sd32768;
        else
            v_clamp = v_round[16:0];
        lim_mag = v_clamp[16] ? 17'(-v_clamp) : 17'(v_clamp);

        mem_we = (state_reg == ST_GATE);
        mem_waddr = {bank_reg, pos_reg};
        mem_raddr = {~bank_reg, pos_reg};

        emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || result_stream.ready);
        fend_ctrl.start = emit_load && last_reg;
        fend_ctrl.agc_enable = agc_en_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_waddr] <= s_filt;
        rd_reg <= frame_mem[mem_raddr];
    end

    acc_limiter u_limiter (
        .clk    (clk),
        .mag    (lim_mag),
        .neg    (v_clamp[16]),
        .result (lim_result)
    );

    acc_fend u_fend (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fend_ctrl),
        .energy    (energy_reg),
        .frame_len (n_eff),
        .smoothed  (smoothed_reg),
        .done      (fend_done),
        .gain      (fend_gain)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_READ;
            ST_READ:   state_next = ST_GATE;
            ST_GATE:   state_next = ST_DIV;
            ST_DIV:    state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_LIM;
            ST_LIM:    state_next = ST_INTERP;
            ST_INTERP: state_next = ST_EMIT;
            ST_EMIT:   if (emit_load) state_next = last_reg ? ST_FEND : ST_IDLE;
            ST_FEND:   if (fend_done) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            frame_samples_reg <= 13'd960;
            channel_count_reg <= 4'd1;
            hpf_coef_reg <= 16'd64815;
            hpf_en_reg <= 1'b0;
            gate_en_reg <= 1'b0;
            agc_en_reg <= 1'b0;
            volume_reg <= 16'd16384;
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                hpf_in_reg[i] <= '0;
                hpf_out_reg[i] <= '0;
            end
            energy_reg <= '0;
            bank_reg <= 1'b0;
            primed_reg <= 1'b0;
            spos_reg <= '0;
            chpos_reg <= '0;
            smoothed_reg <= UNITY_GAIN;
            frame_gain_reg <= UNITY_GAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_SAMPLES:   frame_samples_reg <= cfg_data[FRAME_W-1:0];
                    REG_CHANNEL_COUNT:   channel_count_reg <= cfg_data[CHCNT_W-1:0];
                    REG_HPF_COEFFICIENT: hpf_coef_reg <= cfg_data;
                    REG_HPF_ENABLE:      hpf_en_reg <= cfg_data[0];
                    REG_GATE_ENABLE:     gate_en_reg <= cfg_data[0];
                    REG_AGC_ENABLE:      agc_en_reg <= cfg_data[0];
                    REG_VOLUME_GAIN:     volume_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (state_reg == ST_GATE)
            begin
                energy_reg <= energy_reg + ENERGY_W'(unsigned'(32'(s_filt * s_filt)));
                if (hpf_en_reg)
                begin
                    hpf_in_reg[ch_reg] <= x_reg;
                    hpf_out_reg[ch_reg] <= hpf_y;
                end
            end
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (result_stream.ready)
                out_valid_reg <= 1'b0;
            if (emit_load && !last_reg)
            begin
                spos_reg <= pos_reg + 1'b1;
                chpos_reg <= ({1'b0, ch_reg} + 1'b1 >= nch_eff) ? '0 : ch_reg + 1'b1;
            end
            if (fend_done)
            begin
                smoothed_reg <= fend_gain;
                frame_gain_reg <= fend_gain;
                bank_reg <= ~bank_reg;
                primed_reg <= 1'b1;
                spos_reg <= '0;
                chpos_reg <= '0;
                energy_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= sample_stream.sample_in;
            ch_reg <= ch_accept;
            pos_reg <= spos_reg;
            last_reg <= ({1'b0, spos_reg} + 1'b1) >= n_eff;
        end
        hpf_prod_reg <= hpf_sum * $signed({1'b0, hpf_coef_reg});
        if (state_reg == ST_GATE)
        begin
            s0_reg <= $signed(rd_reg);
            gneg_reg <= s0x[16];
            gzero_reg <= gate_en_reg && (gate_mag <= GATE_CLOSE);
            gscale_reg <= gate_en_reg && (gate_mag > GATE_CLOSE) && (gate_mag < GATE_OPEN);
            gm_reg <= 17'(gate_mag[8:0] * (gate_mag[8:0] - GATE_CLOSE[8:0])) + GATE_HALF;
        end
        if (state_reg == ST_DIV)
        begin
            if (gzero_reg)
                g_reg <= '0;
            else if (gscale_reg)
                g_reg <= gate_qs[15:0];
            else
                g_reg <= s0_reg;
        end
        if (state_reg == ST_MUL1)
            t_reg <= g_reg * $signed({1'b0, frame_gain_reg});
        if (state_reg == ST_MUL2)
            u_reg <= 48'(t_reg * $signed({1'b0, vol_eff}));
        if (state_reg == ST_INTERP)
            res_reg <= lim_result;
        if (emit_load)
        begin
            out_sample_reg <= primed_reg ? res_reg : '0;
            out_last_reg <= primed_reg && last_reg;
            out_gain_reg <= primed_reg ? frame_gain_reg : '0;
        end
    end

    assign result_stream.valid = out_valid_reg;
    assign result_stream.sample_out = out_sample_reg;
    assign result_stream.frame_last = out_last_reg;
    assign result_stream.gain_applied = out_gain_reg;

    `ACC_ASSERT_NEXT(a_bank_toggle, clk, rst_n, fend_done, bank_reg != $past(bank_reg),
        "frame end did not switch the bank")
    `ACC_ASSERT_SAME(a_done_in_fend, clk, rst_n, fend_done, state_reg == ST_FEND,
        "frame-end result arrived outside the frame-end wait")
    `ACC_ASSERT_SAME(a_gain_range, clk, rst_n, emit_load && primed_reg,
        frame_gain_reg >= GAIN_MIN && frame_gain_reg <= GAIN_MAX,
        "emitted gain out of range")

endmodule
`default_nettype wire

// File: hdl/acc_fend.sv
`default_nettype none
module acc_fend (
    input  logic                            clk,
    input  logic                            rst_n,
    input  acc_pkg::fend_ctrl_t             ctrl,
    input  logic [acc_pkg::ENERGY_W-1:0]    energy,
    input  logic [acc_pkg::FRAME_W-1:0]     frame_len,
    input  logic [acc_pkg::GAIN_W-1:0]      smoothed,
    output logic                            done,
    output logic [acc_pkg::GAIN_W-1:0]      gain
);
    import acc_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE  = 6'b000001,
        F_MEAN  = 6'b000010,
        F_ROOT  = 6'b000100,
        F_RECIP = 6'b001000,
        F_SCALE = 6'b010000,
        F_ADD   = 6'b100000
    } fend_state_t;

    fend_state_t state_reg, state_next;
    logic [47:0] dvd_reg, dvd_next;
    logic [24:0] rem_reg, rem_next;
    logic [23:0] dsr_reg, dsr_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [47:0] rad_reg, rad_next;
    logic [47:0] root_reg, root_next;
    logic [47:0] bit_reg, bit_next;
    logic [GAIN_W-1:0] target_reg, target_next;
    logic signed [32:0] prod_reg, prod_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic done_reg, done_next;

    logic [24:0] rem_sh;
    logic take;
    logic [24:0] step_rem;
    logic [47:0] step_dvd;
    logic [47:0] root_sum;
    logic [47:0] root_step;
    logic [47:0] rad_step;
    logic [23:0] rms;
    logic signed [16:0] diff;
    logic signed [32:0] rnd;

    always_comb
    begin
        rem_sh = {rem_reg[23:0], dvd_reg[47]};
        take = rem_sh >= {1'b0, dsr_reg};
        step_rem = take ? rem_sh - {1'b0, dsr_reg} : rem_sh;
        step_dvd = {dvd_reg[46:0], take};

        root_sum = root_reg + bit_reg;
        if (rad_reg >= root_sum)
        begin
            rad_step = rad_reg - root_sum;
            root_step = (root_reg >> 1) + bit_reg;
        end
        else
        begin
            rad_step = rad_reg;
            root_step = root_reg >> 1;
        end
        rms = (root_step < {24'd0, RMS_FLOOR}) ? RMS_FLOOR : root_step[23:0];

        diff = $signed({1'b0, target_reg}) - $signed({1'b0, smoothed});
        rnd = (prod_reg + 33'sd32768 - $signed({32'd0, prod_reg[32]})) >>> 16;

        state_next = state_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        rad_next = rad_reg;
        root_next = root_reg;
        bit_next = bit_reg;
        target_next = target_reg;
        prod_next = prod_reg;
        gain_next = gain_reg;
        done_next = 1'b0;

        case (state_reg)
            F_IDLE:
            begin
                if (ctrl.start)
                begin
                    if (ctrl.agc_enable)
                    begin
                        dvd_next = energy;
                        rem_next = '0;
                        dsr_next = {{(24-FRAME_W){1'b0}}, frame_len};
                        cnt_next = 6'd47;
                        state_next = F_MEAN;
                    end
                    else
                    begin
                        gain_next = UNITY_GAIN;
                        done_next = 1'b1;
                    end
                end
            end
            F_MEAN:
            begin
                dvd_next = step_dvd;
                rem_next = step_rem;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    rad_next = {step_dvd[31:0], 16'd0};
                    root_next = '0;
                    bit_next = 48'd1 << 46;
                    state_next = F_ROOT;
                end
            end
            F_ROOT:
            begin
                rad_next = rad_step;
                root_next = root_step;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    dvd_next = AGC_NUM + {25'd0, rms[23:1]};
                    dsr_next = rms;
                    rem_next = '0;
                    cnt_next = 6'd47;
                    state_next = F_RECIP;
                end
            end
            F_RECIP:
            begin
                dvd_next = step_dvd;
                rem_next = step_rem;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    if (step_dvd < {32'd0, GAIN_MIN})
                        target_next = GAIN_MIN;
                    else if (step_dvd > {32'd0, GAIN_MAX})
                        target_next = GAIN_MAX;
                    else
                        target_next = step_dvd[GAIN_W-1:0];
                    state_next = F_SCALE;
                end
            end
            F_SCALE:
            begin
                prod_next = diff * $signed({1'b0, (target_reg < smoothed) ? K_FALL : K_RISE});
                state_next = F_ADD;
            end
            F_ADD:
            begin
                gain_next = GAIN_W'($signed({1'b0, smoothed}) + rnd);
                done_next = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        rad_reg <= rad_next;
        root_reg <= root_next;
        bit_reg <= bit_next;
        target_reg <= target_next;
        prod_reg <= prod_next;
        gain_reg <= gain_next;
    end

    assign done = done_reg;
    assign gain = gain_reg;

endmodule
`default_nettype wire

// File: hdl/acc_limiter.sv
`default_nettype none
module acc_limiter (
    input  logic                                clk,
    input  logic [16:0]                         mag,
    input  logic                                neg,
    output logic signed [acc_pkg::SAMPLE_BITS-1:0] result
);
    import acc_pkg::*;

    logic [15:0] lo_reg;
    logic [15:0] hi_reg;
    logic [LIM_SHIFT-1:0] frac_reg;
    logic neg_reg;

    logic [LIM_IDX_W-1:0] idx;
    logic [LIM_IDX_W-1:0] idx_hi;
    logic [15+LIM_SHIFT:0] interp;
    logic [16:0] mag_out;
    logic signed [17:0] signed_out;

    always_comb
    begin
        idx = LIM_IDX_W'(mag >> LIM_SHIFT);
        idx_hi = (idx == LIM_IDX_W'(LIMIT_DEPTH)) ? idx : idx + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= LIMIT_TABLE[idx];
        hi_reg <= LIMIT_TABLE[idx_hi];
        frac_reg <= mag[LIM_SHIFT-1:0];
        neg_reg <= neg;
    end

    always_comb
    begin
        interp = (16'(hi_reg - lo_reg) * (16+LIM_SHIFT)'(frac_reg)
                  + (16+LIM_SHIFT)'(1 << (LIM_SHIFT - 1))) >> LIM_SHIFT;
        mag_out = {1'b0, lo_reg} + 17'(interp);
        signed_out = neg_reg ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
        if (signed_out > 18'sd32767)
            result = 16'sh7fff;
        else
            result = signed_out[15:0];
    end

endmodule
`default_nettype wire

// File: dv/tb_audio_capture_conditioner.sv
`timescale 1ns / 100ps
module tb_audio_capture_conditioner;
    import acc_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int errors;
    bit no_wait;

    acc_in_if in_if();
    acc_out_if out_if();

    audio_capture_conditioner dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_stream(in_if.sink),
        .result_stream(out_if.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    class conditioner_sb;
        typedef struct {
            logic signed [15:0] smp;
            logic last;
            logic [15:0] gain;
        } cond_result_t;

        cond_result_t due_q[$];
        int unsigned regs[7];
        int frame_mem[2 * MAX_FRAME_SAMPLES];
        int filled[2];
        bit bank;
        bit primed;
        longint hp_in[MAX_CHANNELS];
        longint hp_out[MAX_CHANNELS];
        longint energy;
        longint agc_gain;
        longint out_gain;
        int pos_now;
        int ch_now;
        longint tanh_tab[0:LIMIT_DEPTH];

        function new();
            longint unsigned full;
            longint unsigned part;
            regs[REG_FRAME_SAMPLES] = 960;
            regs[REG_CHANNEL_COUNT] = 1;
            regs[REG_HPF_COEFFICIENT] = 64815;
            regs[REG_HPF_ENABLE] = 0;
            regs[REG_GATE_ENABLE] = 0;
            regs[REG_AGC_ENABLE] = 0;
            regs[REG_VOLUME_GAIN] = 16384;
            foreach (frame_mem[i]) frame_mem[i] = 0;
            foreach (hp_in[i]) begin
                hp_in[i] = 0;
                hp_out[i] = 0;
            end
            filled[0] = 0;
            filled[1] = 0;
            bank = 0;
            primed = 0;
            energy = 0;
            agc_gain = 16384;
            out_gain = 16384;
            pos_now = 0;
            ch_now = 0;
            full = tanh_q30(64'd858993459);
            for (int i = 0; i <= LIMIT_DEPTH; i++) begin
                part = tanh_q30(longint'(i) * 64'd858993459 / LIMIT_DEPTH);
                tanh_tab[i] = longint'((part * 64'd65536 + full) / (64'd2 * full));
            end
        endfunction

        function longint unsigned tanh_q30(longint unsigned x);
            longint unsigned acc;
            longint unsigned t;
            longint unsigned one;
            one = 64'd1 << 28;
            acc = one;
            t = one;
            for (int k = 1; k < 64; k++) begin
                t = ((t * x) >> 28) / longint'(k);
                if (t == 0) break;
                acc += t;
            end
            return ((acc - one) << 30) / (acc + one);
        endfunction

        function longint shr_round(longint v, int s);
            longint half;
            half = longint'(1) << (s - 1);
            if (v >= 0) return (v + half) >>> s;
            return -((-v + half) >>> s);
        endfunction

        function longint div_round(longint num, longint den);
            longint m;
            m = num < 0 ? -num : num;
            m = (m + den / 2) / den;
            return num < 0 ? -m : m;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint root(longint v);
            longint r;
            r = 0;
            for (int b = 31; b >= 0; b--)
                if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= v)
                    r |= longint'(1) << b;
            return r;
        endfunction

        function longint shape(longint s);
            longint vol, a, v, p, idx, fr, r;
            vol = regs[REG_VOLUME_GAIN] > 32768 ? 32768 : regs[REG_VOLUME_GAIN];
            if (regs[REG_GATE_ENABLE] != 0) begin
                a = s < 0 ? -s : s;
                if (a <= 131) s = 0;
                else if (a < 360) s = div_round(s * (a - 131), 229);
            end
            v = clip(shr_round(s * out_gain * vol, 28), -32768, 32768);
            a = v < 0 ? -v : v;
            p = a * LIMIT_DEPTH;
            idx = p >> 15;
            fr = p & 32767;
            if (idx >= LIMIT_DEPTH) r = tanh_tab[LIMIT_DEPTH];
            else r = tanh_tab[idx]
                + (((tanh_tab[idx + 1] - tanh_tab[idx]) * fr + 16384) >>> 15);
            return clip(v < 0 ? -r : r, -32768, 32767);
        endfunction

        function void set_reg(cfg_reg_t r, int unsigned v);
            case (r)
                REG_FRAME_SAMPLES: regs[r] = v & 13'h1fff;
                REG_CHANNEL_COUNT: regs[r] = v & 4'hf;
                REG_HPF_ENABLE, REG_GATE_ENABLE, REG_AGC_ENABLE: regs[r] = v & 1;
                default: regs[r] = v & 16'hffff;
            endcase
        endfunction

        function int unsigned fit_frame(int unsigned raw);
            int unsigned eff;
            eff = raw == 0 ? 1 : (raw > MAX_FRAME_SAMPLES ? MAX_FRAME_SAMPLES : raw);
            if (primed && eff > filled[bank ^ 1]) return filled[bank ^ 1];
            return raw;
        endfunction

        function void note(logic signed [15:0] x);
            int n, nch, ch, pos;
            longint s, sum, y, mean, rms, target, k;
            cond_result_t e;
            n = regs[REG_FRAME_SAMPLES];
            nch = regs[REG_CHANNEL_COUNT];
            if (n == 0) n = 1;
            if (n > MAX_FRAME_SAMPLES) n = MAX_FRAME_SAMPLES;
            if (nch == 0) nch = 1;
            if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
            ch = ch_now < nch ? ch_now : 0;
            pos = pos_now < MAX_FRAME_SAMPLES ? pos_now : MAX_FRAME_SAMPLES - 1;
            s = x;
            if (regs[REG_HPF_ENABLE] != 0) begin
                sum = hp_out[ch] + (s - hp_in[ch]) * 128;
                y = clip(shr_round(sum * regs[REG_HPF_COEFFICIENT], 16),
                         -(longint'(1) << 23), (longint'(1) << 23) - 1);
                hp_in[ch] = x;
                hp_out[ch] = y;
                s = clip(shr_round(y, 7), -32768, 32767);
            end
            if (primed) begin
                e.smp = 16'(shape(frame_mem[(bank ^ 1) * MAX_FRAME_SAMPLES + pos]));
                e.last = pos + 1 >= n;
                e.gain = 16'(out_gain);
            end else begin
                e.smp = 0;
                e.last = 0;
                e.gain = 0;
            end
            due_q.insert(due_q.size(), e);
            frame_mem[bank * MAX_FRAME_SAMPLES + pos] = int'(s);
            if (filled[bank] < pos + 1) filled[bank] = pos + 1;
            energy += s * s;
            if (pos + 1 >= n) begin
                if (regs[REG_AGC_ENABLE] != 0) begin
                    mean = energy / n;
                    rms = root(mean << 16);
                    if (rms < 67109) rms = 67109;
                    target = clip(div_round(64'd15118284882, rms), 10650, 36045);
                    k = target < agc_gain ? 19661 : 5243;
                    agc_gain += shr_round((target - agc_gain) * k, 16);
                end else begin
                    agc_gain = 16384;
                end
                out_gain = agc_gain;
                bank ^= 1;
                primed = 1;
                pos_now = 0;
                ch_now = 0;
                energy = 0;
            end else begin
                pos_now = pos + 1;
                ch_now = ch + 1 >= nch ? 0 : ch + 1;
            end
        endfunction

        task check(logic signed [15:0] smp, logic last, logic [15:0] gain);
            cond_result_t e;
            if (due_q.size() == 0) begin
                report("result with no item waiting");
                return;
            end
            e = due_q.pop_front();
            if (smp !== e.smp) report($sformatf("sample_out %0d, want %0d", smp, e.smp));
            if (last !== e.last) report($sformatf("frame_last %0b, want %0b", last, e.last));
            if (gain !== e.gain) report($sformatf("gain_applied %0d, want %0d", gain, e.gain));
        endtask

        function int pending();
            return due_q.size();
        endfunction
    endclass

    conditioner_sb sb;

    always #4 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && in_if.valid && in_if.ready) sb.note(in_if.sample_in);
        if (rst_n && out_if.valid && out_if.ready)
            sb.check(out_if.sample_out, out_if.frame_last, out_if.gain_applied);
    end

    initial
    begin
        int stall;
        out_if.ready = 0;
        forever
        begin
            @(negedge clk);
            stall = no_wait ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_if.ready <= 0;
                repeat (stall) @(negedge clk);
            end
            out_if.ready <= 1;
            @(posedge clk);
            while (!out_if.valid) @(posedge clk);
        end
    end

    task automatic send(input logic signed [15:0] v);
        int gap;
        gap = no_wait ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_if.valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid <= 1;
        in_if.sample_in <= v;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_if.valid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input int unsigned v);
        cfg_we <= 1;
        cfg_index <= r;
        cfg_data <= v[15:0];
        sb.set_reg(r, v);
        @(negedge clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 2) return 16'($urandom);
        if (kind == 2) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if (kind < 6) return 16'($signed($urandom_range(0, 800)) - 400);
        return 16'($signed($urandom_range(0, 12000)) - 6000);
    endfunction

    task automatic random_config();
        int unsigned f;
        int sel;
        sel = $urandom_range(0, 9);
        f = sel == 0 ? 0 : (sel == 1 ? $urandom_range(4097, 8191) : $urandom_range(1, 64));
        write_reg(REG_FRAME_SAMPLES, sb.fit_frame(f));
        write_reg(REG_CHANNEL_COUNT, $urandom_range(0, 15));
        sel = $urandom_range(0, 3);
        write_reg(REG_HPF_COEFFICIENT, sel == 0 ? 0 : (sel == 1 ? 65535 :
                                       (sel == 2 ? 64815 : $urandom_range(0, 65535))));
        write_reg(REG_HPF_ENABLE, $urandom_range(0, 1));
        write_reg(REG_GATE_ENABLE, $urandom_range(0, 1));
        write_reg(REG_AGC_ENABLE, $urandom_range(0, 3) != 0);
        sel = $urandom_range(0, 4);
        write_reg(REG_VOLUME_GAIN, sel == 0 ? 0 : (sel == 1 ? 32768 :
                                   (sel == 2 ? 16384 : $urandom_range(0, 65535))));
        cfg_we <= 0;
    endtask

    initial
    begin
        static logic signed [15:0] opening[10] = '{16'sh7fff, 16'sh8000, 0, 1, -1, 131, -131,
                                                    132, 359, -360};
        static logic signed [15:0] gated[8] = '{360, -359, 200, -16384, 16'sh7fff, 16'sh7fff,
                                                16'sh8000, 5};
        static logic signed [15:0] filtered[6] = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                                                   0, 1000};
        int sent;
        int count;
        int phase;
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        in_if.valid = 0;
        in_if.sample_in = 0;
        errors = 0;
        no_wait = 0;
        sb = new();
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        write_reg(REG_FRAME_SAMPLES, 8191);
        write_reg(REG_CHANNEL_COUNT, 0);
        write_reg(REG_HPF_COEFFICIENT, 65535);
        write_reg(REG_HPF_ENABLE, 0);
        write_reg(REG_GATE_ENABLE, 1);
        write_reg(REG_AGC_ENABLE, 1);
        write_reg(REG_VOLUME_GAIN, 32768);
        cfg_we <= 0;
        @(negedge clk);
        foreach (opening[i]) send(opening[i]);
        for (int i = 0; i < 60; i++) send(pick_sample());
        drain();
        write_reg(REG_FRAME_SAMPLES, 64);
        cfg_we <= 0;
        @(negedge clk);
        foreach (gated[i]) send(gated[i]);
        drain();
        write_reg(REG_FRAME_SAMPLES, 3);
        write_reg(REG_CHANNEL_COUNT, 15);
        write_reg(REG_HPF_ENABLE, 1);
        cfg_we <= 0;
        @(negedge clk);
        foreach (filtered[i]) send(filtered[i]);
        drain();

        sent = 0;
        phase = 0;
        while (sent < 670)
        begin
            random_config();
            no_wait = $urandom_range(0, 3) == 0;
            @(negedge clk);
            count = $urandom_range(20, 70);
            for (int i = 0; i < count; i++)
            begin
                if (phase == 3 && i == count / 2)
                begin
                    in_if.valid <= 0;
                    while (sb.pending() != 0) @(posedge clk);
                    @(negedge clk);
                end
                send(pick_sample());
            end
            sent += count;
            phase++;
            drain();
        end

        no_wait = 0;
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
